@@ rtl/frame_descriptor_ring_top_assert.svh @@
// assertion macros for the frame descriptor ring
// used by frame_descriptor_ring_top, no other dependencies
`ifndef FRAME_DESCRIPTOR_RING_TOP_ASSERT_SVH
`define FRAME_DESCRIPTOR_RING_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define FDR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fdr_pkg.sv @@
// shared types and constants of the frame descriptor ring
// used by fdr_front, fdr_back and the top level, depends on nothing
package fdr_pkg;

    localparam int SLOTS        = 64;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int LEN_W        = 25;
    localparam int OFS_W        = 24;
    localparam int SEQ_W        = 32;
    localparam int TS_W         = 64;
    localparam int UT_W         = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam logic [LEN_W-1:0] REGION_RESET = LEN_W'(1048576);

    localparam logic CMD_PUBLISH = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    // class of a word as decided by the front
    typedef enum logic [1:0] {
        K_PUBLISH,
        K_PUB_INVALID,
        K_PUB_NOSPACE,
        K_READ
    } t_kind;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

    typedef struct packed {
        t_kind                   kind;
        logic [LEN_W-1:0]        frame_length;
        logic signed [TS_W-1:0]  time_stamp;
        logic [UT_W-1:0]         unit_type;
        logic                    key_frame;
        logic [SEQ_W-1:0]        read_sequence;
        logic [LEN_W-1:0]        buffer_size;
    } t_item;

    // front to back queue head
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_side;

    // one descriptor slot
    typedef struct packed {
        logic [SEQ_W-1:0]        seq;
        logic [OFS_W-1:0]        offset;
        logic [LEN_W-1:0]        length;
        logic signed [TS_W-1:0]  time_stamp;
        logic [UT_W-1:0]         unit_type;
        logic                    key_flag;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

    typedef struct packed {
        t_status                 status;
        logic [SEQ_W-1:0]        next_read_sequence;
        logic [OFS_W-1:0]        frame_offset;
        logic [LEN_W-1:0]        out_length;
        logic signed [TS_W-1:0]  out_time_stamp;
        logic [UT_W-1:0]         out_unit_type;
        logic                    out_key_frame;
    } t_result;

endpackage

@@ rtl/fdr_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module fdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fdr_front.sv @@
// front of the frame descriptor ring: classifies words and queues them
// depends on fdr_pkg
module fdr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_command,
    input  logic [fdr_pkg::LEN_W-1:0]  i_frame_length,
    input  logic signed [fdr_pkg::TS_W-1:0] i_time_stamp,
    input  logic [fdr_pkg::UT_W-1:0]   i_unit_type,
    input  logic                       i_key_frame,
    input  logic [fdr_pkg::SEQ_W-1:0]  i_read_sequence,
    input  logic [fdr_pkg::LEN_W-1:0]  i_buffer_size,
    input  logic [fdr_pkg::LEN_W-1:0]  i_region_size,
    output fdr_pkg::t_queue_side       o_q,
    input  logic                       i_q_pop
);
    import fdr_pkg::*;

    t_item             r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    t_item             in_item;
    logic              do_push, do_pop;

    // classify the incoming word
    always_comb begin
        in_item.frame_length  = i_frame_length;
        in_item.time_stamp    = i_time_stamp;
        in_item.unit_type     = i_unit_type;
        in_item.key_frame     = i_key_frame;
        in_item.read_sequence = i_read_sequence;
        in_item.buffer_size   = i_buffer_size;
        priority if (i_command == CMD_READ) begin
            in_item.kind = K_READ;
        end else if (i_frame_length == '0) begin
            in_item.kind = K_PUB_INVALID;
        end else if (i_frame_length > i_region_size) begin
            in_item.kind = K_PUB_NOSPACE;
        end else begin
            in_item.kind = K_PUBLISH;
        end
    end

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_q_pop && (r_count != '0);

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_queue[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_queue[r_wr_ptr] <= in_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/fdr_back.sv @@
// back of the frame descriptor ring: carries out publish and read words
// depends on fdr_pkg and fdr_ram (descriptor table)
module fdr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fdr_pkg::t_queue_side       i_q,
    output logic                       o_q_pop,
    input  logic [fdr_pkg::LEN_W-1:0]  i_region_size,
    input  logic                       i_pop,
    output logic                       o_res_valid,
    output fdr_pkg::t_result           o_res
);
    import fdr_pkg::*;

    t_back_state       r_state, n_state;
    logic [LEN_W-1:0]  r_head, n_head;
    logic [SEQ_W-1:0]  r_wseq, n_wseq;
    logic [SLOTS-1:0]  r_slot_valid;
    t_item             r_cur;
    logic              r_hit;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic              out_free, ld_out;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    t_desc             wdesc, rdesc;
    logic [DESC_W-1:0] ram_rdata;
    logic [SEQ_W-1:0]  seq_gap;
    logic              fits;
    logic [LEN_W-1:0]  head_sum;

    fdr_ram #(
        .WIDTH (DESC_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wdesc),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_pop;
    assign seq_gap  = r_wseq - i_q.item.read_sequence;
    assign ram_raddr = i_q.item.read_sequence[SLOT_W-1:0];
    assign head_sum = LEN_W'(r_head + i_q.item.frame_length);
    // tail counts as zero when the head lies past the region
    assign fits     = (r_head <= i_region_size) &&
                      (i_q.item.frame_length <= LEN_W'(i_region_size - r_head));
    // never written slots read as all zero
    assign rdesc    = r_hit ? t_desc'(ram_rdata) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q.valid && out_free && i_q.item.kind == K_READ &&
                    seq_gap != '0 && seq_gap < SEQ_W'(SLOTS)) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop   = 1'b0;
        ld_out    = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        n_out     = '0;
        n_head    = r_head;
        n_wseq    = r_wseq;
        ram_waddr = n_wseq[SLOT_W-1:0];
        wdesc     = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q.valid && out_free) begin
                    o_q_pop = 1'b1;
                    unique case (i_q.item.kind)
                        K_PUB_INVALID: begin
                            ld_out       = 1'b1;
                            n_out.status = ST_INVALID;
                        end
                        K_PUB_NOSPACE: begin
                            ld_out       = 1'b1;
                            n_out.status = ST_NOSPACE;
                        end
                        K_PUBLISH: begin
                            ld_out           = 1'b1;
                            ram_we           = 1'b1;
                            n_wseq           = r_wseq + 1'b1;
                            ram_waddr        = n_wseq[SLOT_W-1:0];
                            n_head           = fits ? head_sum : i_q.item.frame_length;
                            wdesc.seq        = n_wseq;
                            wdesc.offset     = fits ? r_head[OFS_W-1:0] : '0;
                            wdesc.length     = i_q.item.frame_length;
                            wdesc.time_stamp = i_q.item.time_stamp;
                            wdesc.unit_type  = i_q.item.unit_type;
                            wdesc.key_flag   = i_q.item.key_frame;
                            n_out.status       = ST_OK;
                            n_out.frame_offset = wdesc.offset;
                        end
                        K_READ: begin
                            if (seq_gap == '0) begin
                                ld_out                   = 1'b1;
                                n_out.status             = ST_EMPTY;
                                n_out.next_read_sequence = i_q.item.read_sequence;
                            end else if (seq_gap >= SEQ_W'(SLOTS)) begin
                                ld_out                   = 1'b1;
                                n_out.status             = ST_OVERFLOW;
                                n_out.next_read_sequence = r_wseq;
                            end else begin
                                ram_re = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    ld_out = 1'b1;
                    priority if (rdesc.seq != r_cur.read_sequence) begin
                        n_out.status             = ST_OVERFLOW;
                        n_out.next_read_sequence = r_wseq;
                    end else if (rdesc.length > r_cur.buffer_size) begin
                        n_out.status             = ST_NOSPACE;
                        n_out.next_read_sequence = r_cur.read_sequence + 1'b1;
                        n_out.out_length         = rdesc.length;
                    end else begin
                        n_out.status             = ST_OK;
                        n_out.next_read_sequence = r_cur.read_sequence + 1'b1;
                        n_out.frame_offset       = rdesc.offset;
                        n_out.out_length         = rdesc.length;
                        n_out.out_time_stamp     = rdesc.time_stamp;
                        n_out.out_unit_type      = rdesc.unit_type;
                        n_out.out_key_frame      = rdesc.key_flag;
                    end
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_head       <= '0;
            r_wseq       <= '0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_wseq  <= n_wseq;
            if (ram_we) begin
                r_slot_valid[ram_waddr] <= 1'b1;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_cur <= i_q.item;
            r_hit <= r_slot_valid[ram_raddr];
        end
        if (ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ rtl/frame_descriptor_ring_top.sv @@
// frame descriptor ring, single producer and many consumers, descriptor side only
// top level: region size register, front queue and back sequencer
// depends on fdr_pkg, fdr_front, fdr_back and frame_descriptor_ring_top_assert.svh
//
// Usage:
//   Input words enter by push/full, a word is taken when push is high and full
//   is low. command selects a publish (frame_length, time_stamp, unit_type,
//   key_frame) or a consumer read (read_sequence, buffer_size).
//   Each word gives exactly one result word, in order, shown while empty is
//   low and taken when pop is high.
//   Path: a publish or a read answered without the table (empty, overflow by
//   distance) passes the input queue and the result register; a read that
//   looks up the descriptor table also passes the table's registered read port.
//   Throughput: one word per cycle for publishes and short read answers while
//   pop keeps the result register free; a read through the table holds the
//   back in its read state, so the next word waits for the registered read port.
//   A two-word queue sits behind the input and a one-word result register at
//   the output; while pop stays low the queue fills and full rises.
//   Reset: region_size returns to 1048576, head and write sequence clear, and
//   per-slot valid bits make every slot read as zero, with no clearing pass.
//   The user writes region_size (i_cfg_we/i_cfg_wdata) only when idle; unchecked.
`include "frame_descriptor_ring_top_assert.svh"

module frame_descriptor_ring_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fdr_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_command,
    input  logic [fdr_pkg::LEN_W-1:0]  i_frame_length,
    input  logic signed [fdr_pkg::TS_W-1:0] i_time_stamp,
    input  logic [fdr_pkg::UT_W-1:0]   i_unit_type,
    input  logic                       i_key_frame,
    input  logic [fdr_pkg::SEQ_W-1:0]  i_read_sequence,
    input  logic [fdr_pkg::LEN_W-1:0]  i_buffer_size,
    output logic                       empty,
    input  logic                       pop,
    output logic [2:0]                 o_status,
    output logic [fdr_pkg::SEQ_W-1:0]  o_next_read_sequence,
    output logic [fdr_pkg::OFS_W-1:0]  o_frame_offset,
    output logic [fdr_pkg::LEN_W-1:0]  o_out_length,
    output logic signed [fdr_pkg::TS_W-1:0] o_out_time_stamp,
    output logic [fdr_pkg::UT_W-1:0]   o_out_unit_type,
    output logic                       o_out_key_frame
);
    import fdr_pkg::*;

    logic [LEN_W-1:0] r_region_size;
    t_queue_side      q_side;
    logic             q_pop;
    logic             res_valid;
    t_result          res;

    // region size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= REGION_RESET;
        end else if (i_cfg_we) begin
            r_region_size <= i_cfg_wdata;
        end
    end

    fdr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_command       (i_command),
        .i_frame_length  (i_frame_length),
        .i_time_stamp    (i_time_stamp),
        .i_unit_type     (i_unit_type),
        .i_key_frame     (i_key_frame),
        .i_read_sequence (i_read_sequence),
        .i_buffer_size   (i_buffer_size),
        .i_region_size   (r_region_size),
        .o_q             (q_side),
        .i_q_pop         (q_pop)
    );

    fdr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q_side),
        .o_q_pop       (q_pop),
        .i_region_size (r_region_size),
        .i_pop         (pop),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // result word on the ports
    assign empty                = !res_valid;
    assign o_status             = res.status;
    assign o_next_read_sequence = res.next_read_sequence;
    assign o_frame_offset       = res.frame_offset;
    assign o_out_length         = res.out_length;
    assign o_out_time_stamp     = res.out_time_stamp;
    assign o_out_unit_type      = res.out_unit_type;
    assign o_out_key_frame      = res.out_key_frame;

    // checks
    `FDR_ASSERT_NEXT(a_reset_drains, i_clk, 1'b1, !i_rst_n, empty && !full,
        "reset left words in flight")
    `FDR_ASSERT_SAME(a_overflow_clean, i_clk, i_rst_n, !empty && o_status == ST_OVERFLOW,
        o_frame_offset == '0 && o_out_length == '0 && o_out_key_frame == 1'b0,
        "overflow word carries descriptor data")
    `FDR_ASSERT_SAME(a_error_no_offset, i_clk, i_rst_n,
        !empty && (o_status == ST_INVALID || o_status == ST_NOSPACE || o_status == ST_EMPTY),
        o_frame_offset == '0 && o_out_time_stamp == '0,
        "error word carries an offset or timestamp")

endmodule
